FILE: hw/rtl/slot_registry_allocator_defines.svh
// Assertion macros shared by the slot registry allocator RTL.
`ifndef SLOT_REGISTRY_ALLOCATOR_DEFINES_SVH
`define SLOT_REGISTRY_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot registry allocator: check failed");

// Next-cycle implication, disabled during reset
`define SRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot registry allocator: check failed");

`endif

FILE: hw/rtl/sra_pkg.sv
// Types and constants shared by the slot registry allocator modules.
package sra_pkg;

   localparam int KIND_W        = 2;
   localparam int SLOT_INDEX_W  = 8;
   localparam int OBJECT_ID_W   = 64;
   localparam int STATUS_W      = 2;
   localparam int PLACED_W      = 6;
   localparam int REQ_TUSER_W   = 3;
   localparam int REQ_TDATA_W   = 72;
   localparam int RSP_TDATA_W   = 72;

   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTER   = 2'd0,
      KIND_UNREGISTER = 2'd1,
      KIND_LOOKUP     = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OCCUPIED  = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

FILE: hw/rtl/sra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sra_ctrl.sv
// Controller state machine: takes a transaction, then commits it.
module sra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sra_pkg::stat_type   stat,
   output sra_pkg::cmd_type    cmd
);

   sra_pkg::state_type state_ff;
   sra_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sra_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         sra_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sra_pkg::STATE_EXEC;
            end
         end
         sra_pkg::STATE_EXEC: begin
            // Wait until the result register can take the outcome
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = sra_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = sra_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/sra_datapath.sv
// Datapath: request register, valid bits, free search, pointer, id RAM, result register.
`include "slot_registry_allocator_defines.svh"

module sra_datapath #(
   parameter int SLOTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sra_pkg::cmd_type                    cmd,
   output sra_pkg::stat_type                   stat,
   input  logic [sra_pkg::KIND_W-1:0]          in_kind,
   input  logic                                in_auto_place,
   input  logic [sra_pkg::SLOT_INDEX_W-1:0]    in_slot_index,
   input  logic [sra_pkg::OBJECT_ID_W-1:0]     in_object_id,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sra_pkg::STATUS_W-1:0]        out_status,
   output logic [sra_pkg::PLACED_W-1:0]        out_placed_index,
   output logic [sra_pkg::OBJECT_ID_W-1:0]     out_found_id
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int PTR_W = $clog2(SLOTS + 1);

   // Held request
   logic [sra_pkg::KIND_W-1:0]       kind_ff;
   logic                             auto_ff;
   logic [sra_pkg::SLOT_INDEX_W-1:0] slot_ff;
   logic [sra_pkg::OBJECT_ID_W-1:0]  obj_ff;

   // Table state
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;

   // Result register
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [sra_pkg::STATUS_W-1:0]     status_ff;
   logic [sra_pkg::PLACED_W-1:0]     placed_ff;
   logic [sra_pkg::OBJECT_ID_W-1:0]  found_ff;

   // Decision signals
   logic [IDX_W-1:0]                 req_idx;
   logic                             in_range;
   logic [SLOTS-1:0]                 cand;
   logic [SLOTS-1:0]                 lowest;
   logic                             any_free;
   logic [IDX_W-1:0]                 free_idx;
   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_idx;
   logic                             clr_en;
   logic                             ptr_en;
   logic [PTR_W-1:0]                 ptr_new;
   sra_pkg::status_type              status_c;
   logic [sra_pkg::PLACED_W-1:0]     placed_c;
   logic [sra_pkg::OBJECT_ID_W-1:0]  found_c;
   logic [sra_pkg::OBJECT_ID_W-1:0]  rd_data;
   logic [IDX_W-1:0]                 rd_addr;

   // Capture the request on acceptance
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= in_kind;
         auto_ff <= in_auto_place;
         slot_ff <= in_slot_index;
         obj_ff  <= in_object_id;
      end
   end

   // Read the id entry as the transaction is taken
   assign rd_addr = IDX_W'(in_slot_index);

   // Write the id entry only when the held transaction commits
   sra_ram #(
      .WIDTH (sra_pkg::OBJECT_ID_W),
      .DEPTH (SLOTS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en & cmd.commit),
      .wr_addr (wr_idx),
      .wr_data (obj_ff),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_idx  = IDX_W'(slot_ff);
   assign in_range = 32'(slot_ff) < 32'(SLOTS);

   // Free slots at or after the pointer
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         cand[i] = ~valid_ff[i] & (PTR_W'(i) >= ptr_ff);
      end
   end

   // Isolate the lowest candidate and encode it
   assign lowest   = cand & (~cand + SLOTS'(1));
   assign any_free = |cand;

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lowest[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   // Decide the outcome of the held request
   always_comb begin
      status_c = sra_pkg::STATUS_RANGE;
      placed_c = '0;
      found_c  = '0;
      wr_en    = 1'b0;
      wr_idx   = req_idx;
      clr_en   = 1'b0;
      ptr_en   = 1'b0;
      ptr_new  = PTR_W'(SLOTS);
      case (sra_pkg::kind_type'(kind_ff))
         sra_pkg::KIND_REGISTER: begin
            if (auto_ff) begin
               ptr_en = 1'b1;
               if (any_free) begin
                  status_c = sra_pkg::STATUS_OK;
                  wr_en    = 1'b1;
                  wr_idx   = free_idx;
                  placed_c = sra_pkg::PLACED_W'(free_idx);
                  ptr_new  = PTR_W'(free_idx) + PTR_W'(1);
               end
            end else if (in_range) begin
               if (valid_ff[req_idx]) begin
                  status_c = sra_pkg::STATUS_OCCUPIED;
               end else begin
                  status_c = sra_pkg::STATUS_OK;
                  wr_en    = 1'b1;
                  placed_c = sra_pkg::PLACED_W'(req_idx);
               end
            end
         end
         sra_pkg::KIND_UNREGISTER: begin
            if (in_range) begin
               if (valid_ff[req_idx]) begin
                  status_c = sra_pkg::STATUS_OK;
                  clr_en   = 1'b1;
               end else begin
                  status_c = sra_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         sra_pkg::KIND_LOOKUP: begin
            if (in_range) begin
               if (valid_ff[req_idx]) begin
                  status_c = sra_pkg::STATUS_OK;
                  found_c  = rd_data;
               end else begin
                  status_c = sra_pkg::STATUS_NOT_FOUND;
               end
            end
         end
         default: begin
            status_c = sra_pkg::STATUS_RANGE;
         end
      endcase
   end

   // Next valid bits and pointer
   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (cmd.commit) begin
         if (wr_en) begin
            valid_in[wr_idx] = 1'b1;
         end
         if (clr_en) begin
            valid_in[req_idx] = 1'b0;
         end
         if (ptr_en) begin
            ptr_in = ptr_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Result register: load on commit, drop once taken
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_c;
         placed_ff <= placed_c;
         found_ff  <= found_c;
      end
   end

   assign stat.out_free    = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign out_status       = status_ff;
   assign out_placed_index = placed_ff;
   assign out_found_id     = found_ff;

   // Checks
   `SRA_ASSERT_NOW(a_ptr_bound, clock, reset, 1'b1, ptr_ff <= PTR_W'(SLOTS))
   `SRA_ASSERT_NOW(a_ptr_forward, clock, reset, !$past(reset), ptr_ff >= $past(ptr_ff))
   `SRA_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid_ff)
   `SRA_ASSERT_NEXT(a_write_marks, clock, reset, cmd.commit && wr_en, valid_ff[$past(wr_idx)])

endmodule

FILE: hw/rtl/slot_registry_allocator.sv
// Slot registry allocator: takes one transaction at a time and commits it before the next.
// A request is taken in IDLE and committed in EXEC, where commit waits while the previous
// result still waits on rsp_tready; its result is then shown from the result register.
// No new request is taken until it commits. Each request reads the id RAM on take and writes
// it at most once, on commit. Reset clears valid bits and the scan pointer, not the id RAM.
module slot_registry_allocator #(
   parameter int SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] slot_index, [71:8] object_id
   input  logic [sra_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] kind, [2] auto_place
   input  logic [sra_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [7:2] placed_index, [71:8] found_id
   output logic [sra_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   sra_pkg::cmd_type  cmd;
   sra_pkg::stat_type stat;

   logic [sra_pkg::STATUS_W-1:0]    status;
   logic [sra_pkg::PLACED_W-1:0]    placed_index;
   logic [sra_pkg::OBJECT_ID_W-1:0] found_id;

   sra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sra_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_kind          (req_tuser[1:0]),
      .in_auto_place    (req_tuser[2]),
      .in_slot_index    (req_tdata[7:0]),
      .in_object_id     (req_tdata[71:8]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .out_status       (status),
      .out_placed_index (placed_index),
      .out_found_id     (found_id)
   );

   assign rsp_tdata = {found_id, placed_index, status};

endmodule

FILE: tb/slot_registry_checker.sv
// Checker for the slot registry allocator: tracks the table, predicts each result and compares.
module slot_registry_checker
   import sra_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // [7:0] slot_index, [71:8] object_id
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] kind, [2] auto_place
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status, [7:2] placed_index, [71:8] found_id
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type            status;
      logic [PLACED_W-1:0]   placed;
      logic [OBJECT_ID_W-1:0] found;
   } outcome_type;

   // Shadow copy of the table and the forward-only scan pointer
   logic [OBJECT_ID_W-1:0] slot_id [SLOTS];
   logic                   slot_taken [SLOTS];
   int                     scan_ptr;
   outcome_type            outcomes_due [$];
   int                     failures;

   // Apply one request to the shadow table and return the result it must give
   function automatic outcome_type apply_request(input logic [KIND_W-1:0] kind_bits,
                                                 input logic auto_place,
                                                 input logic [SLOT_INDEX_W-1:0] slot,
                                                 input logic [OBJECT_ID_W-1:0] id);
      outcome_type o;
      bit          in_range;
      o        = '{status: STATUS_RANGE, placed: '0, found: '0};
      in_range = int'(slot) < SLOTS;
      case (kind_type'(kind_bits))
         KIND_REGISTER: begin
            if (!auto_place) begin
               if (!in_range) begin
                  o.status = STATUS_RANGE;
               end else if (slot_taken[slot]) begin
                  o.status = STATUS_OCCUPIED;
               end else begin
                  slot_id[slot]    = id;
                  slot_taken[slot] = 1'b1;
                  o.status         = STATUS_OK;
                  o.placed         = slot[PLACED_W-1:0];
               end
            end else begin
               // skip occupied slots; the pointer never moves back
               while (scan_ptr < SLOTS && slot_taken[scan_ptr]) scan_ptr++;
               if (scan_ptr >= SLOTS) begin
                  scan_ptr = SLOTS;
                  o.status = STATUS_RANGE;
               end else begin
                  slot_id[scan_ptr]    = id;
                  slot_taken[scan_ptr] = 1'b1;
                  o.status             = STATUS_OK;
                  o.placed             = scan_ptr[PLACED_W-1:0];
                  scan_ptr++;
               end
            end
         end
         KIND_UNREGISTER: begin
            if (!in_range) begin
               o.status = STATUS_RANGE;
            end else if (!slot_taken[slot]) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               slot_taken[slot] = 1'b0;
               o.status         = STATUS_OK;
            end
         end
         KIND_LOOKUP: begin
            if (!in_range) begin
               o.status = STATUS_RANGE;
            end else if (!slot_taken[slot]) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               o.status = STATUS_OK;
               o.found  = slot_id[slot];
            end
         end
         default: o.status = STATUS_RANGE;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : scoreboard
      outcome_type seen;
      outcome_type due;
      if (reset) begin
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         scan_ptr = 0;
         outcomes_due.delete();
         failures = 0;
      end else begin
         // compare a returned transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.status = status_type'(rsp_tdata[1:0]);
            seen.placed = rsp_tdata[7:2];
            seen.found  = rsp_tdata[71:8];
            if (outcomes_due.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t checker: unexpected result status=%0d placed=%0d id=%h",
                           $realtime, seen.status, seen.placed, seen.found);
            end else begin
               due = outcomes_due.pop_front();
               if (seen.status !== due.status || seen.placed !== due.placed ||
                   seen.found !== due.found) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"%0t checker: mismatch expected status=%0d placed=%0d id=%h",
                               " got status=%0d placed=%0d id=%h"}, $realtime,
                              due.status, due.placed, due.found,
                              seen.status, seen.placed, seen.found);
               end
            end
         end
         // predict the result of an accepted request and queue it at the tail
         if (req_tvalid && req_tready)
            outcomes_due = {outcomes_due, apply_request(req_tuser[1:0], req_tuser[2],
                                                        req_tdata[7:0], req_tdata[71:8])};
      end
      fail_count  <= failures;
      outstanding <= outcomes_due.size();
   end

endmodule

FILE: tb/tb.sv
// Testbench top for the slot registry allocator: clock, reset, stimulus, sink and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sra_pkg::*;

   localparam int SLOTS        = 64;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int PHASE_ITEMS  = 440;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 4000;
   localparam int SETTLE       = 20;
   localparam int SENDER_IDLE [4] = '{0, 78, 0, 24};
   localparam int SINK_STALL  [4] = '{0, 0, 78, 24};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [7:0] slot_index, [71:8] object_id
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [1:0] kind, [2] auto_place
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [1:0] status, [7:2] placed_index, [71:8] found_id
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int requests_sent = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   always #(HALF_PERIOD) clock = ~clock;

   slot_registry_allocator #(.SLOTS(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   slot_registry_checker #(.SLOTS(SLOTS)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Offer one request, idling first at the current rate, and hold it until taken
   task automatic send_request(input kind_type kind, input logic auto_place,
                               input logic [SLOT_INDEX_W-1:0] slot,
                               input logic [OBJECT_ID_W-1:0] id);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {auto_place, kind};
      req_tdata  <= {id, slot};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Mostly slots in range, some beyond, a few at the boundaries
   function automatic logic [SLOT_INDEX_W-1:0] random_slot();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) return SLOT_INDEX_W'($urandom_range(SLOTS - 1));
      if (pick < 92) return SLOT_INDEX_W'($urandom_range(255, SLOTS));
      case ($urandom_range(3))
         0:       return '0;
         1:       return SLOT_INDEX_W'(SLOTS - 1);
         2:       return SLOT_INDEX_W'(SLOTS);
         default: return '1;
      endcase
   endfunction

   function automatic logic [OBJECT_ID_W-1:0] random_id();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return '0;
      if (pick < 10) return '1;
      return {$urandom, $urandom};
   endfunction

   // One burst: a register/lookup/free sequence on one slot, or a single loose request
   task automatic random_burst();
      logic [SLOT_INDEX_W-1:0] slot;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         slot = SLOT_INDEX_W'($urandom_range(SLOTS - 1));
         send_request(KIND_REGISTER, 1'b0, slot, random_id());
         send_request(KIND_LOOKUP, 1'($urandom), slot, random_id());
         if ($urandom_range(1)) begin
            send_request(KIND_UNREGISTER, 1'($urandom), slot, random_id());
            send_request(KIND_LOOKUP, 1'($urandom), slot, random_id());
         end
      end else if (pick < 65) begin
         send_request(KIND_REGISTER, 1'($urandom_range(99) < 10), random_slot(),
                      random_id());
      end else if (pick < 82) begin
         send_request(KIND_UNREGISTER, 1'($urandom), random_slot(), random_id());
      end else begin
         send_request(KIND_LOOKUP, 1'($urandom), random_slot(), random_id());
      end
   endtask

   // Result sink: take freely, then one long hold-off, then stall at the phase rate
   initial begin : result_sink
      int held;
      while (reset) @(posedge clock);
      repeat (40) begin
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
      rsp_tready <= 1'b0;
      for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
      forever begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         @(posedge clock);
      end
   end

   // End the run when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int phase_end;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, boundaries, occupied slot, pointer skipping and no reuse
      send_request(KIND_LOOKUP,     1'b0, 8'd0,   '0);
      send_request(KIND_UNREGISTER, 1'b0, 8'd5,   '0);
      send_request(KIND_REGISTER,   1'b0, 8'd0,   '1);
      send_request(KIND_REGISTER,   1'b0, 8'd0,   64'h0123_4567_89ab_cdef);
      send_request(KIND_REGISTER,   1'b0, 8'(SLOTS - 1), '0);
      send_request(KIND_REGISTER,   1'b0, 8'(SLOTS), 64'hdead_beef_0000_0001);
      send_request(KIND_REGISTER,   1'b0, 8'd255, 64'hdead_beef_0000_0002);
      send_request(KIND_REGISTER,   1'b0, 8'd1,   64'h5555_aaaa_5555_aaaa);
      send_request(KIND_REGISTER,   1'b1, 8'd200, 64'haaaa_5555_aaaa_5555);
      send_request(KIND_LOOKUP,     1'b0, 8'd2,   '0);
      send_request(KIND_LOOKUP,     1'b1, 8'(SLOTS - 1), '1);
      send_request(KIND_LOOKUP,     1'b0, 8'(SLOTS), '0);
      send_request(KIND_LOOKUP,     1'b0, 8'd255, '0);
      send_request(KIND_UNREGISTER, 1'b0, 8'd255, '0);
      send_request(KIND_UNREGISTER, 1'b1, 8'(SLOTS), '1);
      send_request(KIND_UNREGISTER, 1'b0, 8'd2,   '0);
      send_request(KIND_REGISTER,   1'b1, 8'd0,   64'hf0f0_0f0f_f0f0_0f0f);
      send_request(KIND_LOOKUP,     1'b0, 8'd2,   '0);
      send_request(KIND_LOOKUP,     1'b0, 8'd0,   '0);
      send_request(KIND_UNREGISTER, 1'b0, 8'd0,   '0);
      send_request(KIND_UNREGISTER, 1'b0, 8'd0,   '0);
      send_request(KIND_LOOKUP,     1'b0, 8'd3,   '0);
      drain_results();

      // Random phases, each with its own idle and stall rates; pause between them
      for (phase = 0; phase < 4; phase++) begin
         req_idle_pct  = SENDER_IDLE[phase];
         rsp_stall_pct = SINK_STALL[phase];
         phase_end     = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_end) random_burst();
         // exhaust the scan pointer: more automatic registers than there are slots
         if (phase == 3)
            repeat (SLOTS + 2) send_request(KIND_REGISTER, 1'b1, random_slot(), random_id());
         drain_results();
      end

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

FILE: slot_registry_allocator.f
+incdir+hw/rtl
hw/rtl/sra_pkg.sv
hw/rtl/sra_ram.sv
hw/rtl/sra_ctrl.sv
hw/rtl/sra_datapath.sv
hw/rtl/slot_registry_allocator.sv
tb/slot_registry_checker.sv
tb/tb.sv
